// ===== rtl/core/crf_pkg.sv =====
// ----------------------------------------------------------------------------
// crf_pkg: shared definitions for the clipped rectangle fill engine
// Widths, limits, register indexes, operation codes and the channel layout
// bundle used by the fill engine and its channel interfaces.
// ----------------------------------------------------------------------------
`default_nettype none

package crf_pkg;

   // Screen and framebuffer limits.
   localparam int MAX_SIDE  = 4096;
   localparam int MAX_PITCH = 16384;

   // Field widths.
   localparam int SIDE_W      = 13;
   localparam int LB_W        = 15;
   localparam int COORD_W     = 16;
   localparam int COLOR_W     = 24;
   localparam int PIXEL_W     = 32;
   localparam int INDEX_W     = 25;
   localparam int LAYOUT_W    = 9;
   localparam int PRODUCT_W   = SIDE_W + LB_W;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   // Longest channel field; longer lengths are treated as this one.
   localparam logic [3:0] MAX_CHANNEL_LEN = 4'd8;

   // Register reset values.
   localparam logic [LAYOUT_W-1:0] RED_LAYOUT_RST    = 9'd171;
   localparam logic [LAYOUT_W-1:0] GREEN_LAYOUT_RST  = 9'd197;
   localparam logic [LAYOUT_W-1:0] BLUE_LAYOUT_RST   = 9'd160;
   localparam logic [LAYOUT_W-1:0] ALPHA_LAYOUT_RST  = 9'd0;
   localparam logic [SIDE_W-1:0]   SCREEN_WIDTH_RST  = 13'd800;
   localparam logic [SIDE_W-1:0]   SCREEN_HEIGHT_RST = 13'd480;
   localparam logic [LB_W-1:0]     PITCH_RST         = 15'd1600;

   typedef enum logic {
      OP_START = 1'b0,
      OP_STEP  = 1'b1
   } op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PIXEL_WIDE    = 3'd0,
      CSR_RED_LAYOUT    = 3'd1,
      CSR_GREEN_LAYOUT  = 3'd2,
      CSR_BLUE_LAYOUT   = 3'd3,
      CSR_ALPHA_LAYOUT  = 3'd4,
      CSR_SCREEN_WIDTH  = 3'd5,
      CSR_SCREEN_HEIGHT = 3'd6,
      CSR_ROW_PITCH     = 3'd7
   } csr_index_type;

   // Pixel format settings handed to the color converter.
   typedef struct packed {
      logic                pixel_wide;
      logic [LAYOUT_W-1:0] red;
      logic [LAYOUT_W-1:0] green;
      logic [LAYOUT_W-1:0] blue;
      logic [LAYOUT_W-1:0] alpha;
   } layout_type;

endpackage

`default_nettype wire

// ===== rtl/core/crf_if.sv =====
// ----------------------------------------------------------------------------
// crf_if: channel interfaces of the clipped rectangle fill engine
// Request, response and register write channels, each with valid and ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface crf_req_if import crf_pkg::*; ;
   logic                       valid;
   logic                       ready;
   logic                       operation;
   logic signed [COORD_W-1:0]  rect_x;
   logic signed [COORD_W-1:0]  rect_y;
   logic signed [COORD_W-1:0]  rect_w;
   logic signed [COORD_W-1:0]  rect_h;
   logic        [COLOR_W-1:0]  fill_color;

   modport source (output valid, operation, rect_x, rect_y, rect_w, rect_h, fill_color,
                   input ready);
   modport sink   (input valid, operation, rect_x, rect_y, rect_w, rect_h, fill_color,
                   output ready);
endinterface

interface crf_rsp_if import crf_pkg::*; ;
   logic               valid;
   logic               ready;
   logic [INDEX_W-1:0] word_index;
   logic [PIXEL_W-1:0] pixel_value;
   logic               last_write;

   modport source (output valid, word_index, pixel_value, last_write, input ready);
   modport sink   (input valid, word_index, pixel_value, last_write, output ready);
endinterface

interface crf_csr_if import crf_pkg::*; ;
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/crf_pixel.sv =====
// ----------------------------------------------------------------------------
// crf_pixel: color to native pixel conversion
// Keeps the top bits of each color byte, places them at their field offsets
// and, in 32-bit mode, sets the alpha field to all ones.
// ----------------------------------------------------------------------------
`default_nettype none

module crf_pixel import crf_pkg::*; (
   input  logic [COLOR_W-1:0] fill_color,
   input  layout_type         layout,
   output logic [PIXEL_W-1:0] pixel
);

   function automatic logic [3:0] field_len(input logic [LAYOUT_W-1:0] lay);
      return (lay[8:5] > MAX_CHANNEL_LEN) ? MAX_CHANNEL_LEN : lay[8:5];
   endfunction

   function automatic logic [PIXEL_W-1:0] place_channel(input logic [7:0] chan,
                                                        input logic [LAYOUT_W-1:0] lay);
      logic [7:0] kept;
      kept = chan >> (MAX_CHANNEL_LEN - field_len(lay));
      return {24'b0, kept} << lay[4:0];
   endfunction

   logic [PIXEL_W-1:0] rgb;
   logic [3:0]         alpha_len;
   logic [8:0]         alpha_mask;
   logic [PIXEL_W-1:0] alpha_bits;

   always_comb begin
      rgb = place_channel(fill_color[23:16], layout.red)
          | place_channel(fill_color[15:8], layout.green)
          | place_channel(fill_color[7:0], layout.blue);
      // A zero length gives an empty mask, so no alpha bit is set.
      alpha_len  = field_len(layout.alpha);
      alpha_mask = (9'd1 << alpha_len) - 9'd1;
      alpha_bits = {24'b0, alpha_mask[7:0]} << layout.alpha[4:0];
      if (layout.pixel_wide) begin
         pixel = rgb | alpha_bits;
      end else begin
         pixel = {16'b0, rgb[15:0]};
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/clipped_rectangle_fill.sv =====
// ----------------------------------------------------------------------------
// clipped_rectangle_fill: rectangle fill engine with screen clipping
// A start item loads a clipped rectangle and a converted pixel; each step item
// taken while a fill runs yields one framebuffer write in row-major order.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake      Carries
//  req_bus   in         valid/ready    operation, rectangle, fill color
//  rsp_bus   out        valid/ready    word index, pixel value, last flag
//  csr_bus   in         valid/ready    register index, write data
//
// Throughput is one item per cycle while rsp_bus does not stall. A step that
// yields a write shows it on rsp_bus after the input register, the product
// register behind the row-times-pitch multiplier and the result register.
// Reset is synchronous and active high; it empties the pipeline, stops any
// fill and restores the register defaults. A stall on rsp_bus backs up one
// stage at a time, and items are still taken while any stage is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module clipped_rectangle_fill import crf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   crf_req_if.sink     req_bus,
   crf_rsp_if.source   rsp_bus,
   crf_csr_if.sink     csr_bus
);

   // ------------------------------------------------------------------
   // Configuration registers. Screen sizes and the line pitch are stored
   // already clamped to their limits, since nothing reads them back.
   // ------------------------------------------------------------------
   logic                pixel_wide_ff;
   logic [LAYOUT_W-1:0] red_layout_ff;
   logic [LAYOUT_W-1:0] green_layout_ff;
   logic [LAYOUT_W-1:0] blue_layout_ff;
   logic [LAYOUT_W-1:0] alpha_layout_ff;
   logic [SIDE_W-1:0]   screen_width_ff;
   logic [SIDE_W-1:0]   screen_height_ff;
   logic [LB_W-1:0]     row_pitch_ff;

   logic [SIDE_W-1:0]   side_clamped;
   logic [LB_W-1:0]     pitch_clamped;

   assign csr_bus.ready = 1'b1;

   always_comb begin
      side_clamped  = (csr_bus.data[SIDE_W-1:0] > SIDE_W'(MAX_SIDE))
                    ? SIDE_W'(MAX_SIDE) : csr_bus.data[SIDE_W-1:0];
      pitch_clamped = (csr_bus.data[LB_W-1:0] > LB_W'(MAX_PITCH))
                    ? LB_W'(MAX_PITCH) : csr_bus.data[LB_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pixel_wide_ff    <= 1'b0;
         red_layout_ff    <= RED_LAYOUT_RST;
         green_layout_ff  <= GREEN_LAYOUT_RST;
         blue_layout_ff   <= BLUE_LAYOUT_RST;
         alpha_layout_ff  <= ALPHA_LAYOUT_RST;
         screen_width_ff  <= SCREEN_WIDTH_RST;
         screen_height_ff <= SCREEN_HEIGHT_RST;
         row_pitch_ff     <= PITCH_RST;
      end else if (csr_bus.valid) begin
         case (csr_index_type'(csr_bus.index))
            CSR_PIXEL_WIDE:    pixel_wide_ff    <= csr_bus.data[0];
            CSR_RED_LAYOUT:    red_layout_ff    <= csr_bus.data[LAYOUT_W-1:0];
            CSR_GREEN_LAYOUT:  green_layout_ff  <= csr_bus.data[LAYOUT_W-1:0];
            CSR_BLUE_LAYOUT:   blue_layout_ff   <= csr_bus.data[LAYOUT_W-1:0];
            CSR_ALPHA_LAYOUT:  alpha_layout_ff  <= csr_bus.data[LAYOUT_W-1:0];
            CSR_SCREEN_WIDTH:  screen_width_ff  <= side_clamped;
            CSR_SCREEN_HEIGHT: screen_height_ff <= side_clamped;
            CSR_ROW_PITCH:     row_pitch_ff     <= pitch_clamped;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Pipeline flow control, from the output backward.
   // ------------------------------------------------------------------
   logic rsp_valid_ff;
   logic prod_valid_ff;
   logic in_valid_ff;
   logic rsp_free;
   logic prod_free;
   logic req_ready;
   logic consume;

   assign rsp_free  = !rsp_valid_ff || rsp_bus.ready;
   assign prod_free = !prod_valid_ff || rsp_free;
   assign req_ready = !in_valid_ff || prod_free;
   assign consume   = in_valid_ff && prod_free;

   assign req_bus.ready = req_ready;

   // ------------------------------------------------------------------
   // Input register.
   // ------------------------------------------------------------------
   op_type                    in_op_ff;
   logic signed [COORD_W-1:0] in_x_ff;
   logic signed [COORD_W-1:0] in_y_ff;
   logic signed [COORD_W-1:0] in_w_ff;
   logic signed [COORD_W-1:0] in_h_ff;
   logic        [COLOR_W-1:0] in_color_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_bus.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_bus.valid && req_ready) begin
         in_op_ff    <= op_type'(req_bus.operation);
         in_x_ff     <= req_bus.rect_x;
         in_y_ff     <= req_bus.rect_y;
         in_w_ff     <= req_bus.rect_w;
         in_h_ff     <= req_bus.rect_h;
         in_color_ff <= req_bus.fill_color;
      end
   end

   // ------------------------------------------------------------------
   // Clipping. The right and bottom edges are exclusive: the rectangle
   // ends at the smaller of its own edge and the screen edge, and starts
   // at its own corner or at zero. It is empty when the end is not past
   // the start on either axis.
   // ------------------------------------------------------------------
   logic signed [17:0] x_s, y_s;
   logic signed [17:0] right_raw, bottom_raw;
   logic signed [17:0] right_s, bottom_s;
   logic signed [17:0] left_s, top_s;
   logic signed [17:0] col_last_s, row_last_s;
   logic signed [17:0] width_s, height_s;
   logic               clip_empty;

   always_comb begin
      x_s        = 18'(in_x_ff);
      y_s        = 18'(in_y_ff);
      width_s    = signed'({5'b0, screen_width_ff});
      height_s   = signed'({5'b0, screen_height_ff});
      right_raw  = x_s + 18'(in_w_ff);
      bottom_raw = y_s + 18'(in_h_ff);
      right_s    = (right_raw > width_s) ? width_s : right_raw;
      bottom_s   = (bottom_raw > height_s) ? height_s : bottom_raw;
      left_s     = x_s[17] ? 18'sd0 : x_s;
      top_s      = y_s[17] ? 18'sd0 : y_s;
      col_last_s = right_s - 18'sd1;
      row_last_s = bottom_s - 18'sd1;
      clip_empty = (right_s <= left_s) || (bottom_s <= top_s);
   end

   // ------------------------------------------------------------------
   // Color conversion for the start item.
   // ------------------------------------------------------------------
   layout_type         layout;
   logic [PIXEL_W-1:0] start_pixel;

   assign layout = '{pixel_wide: pixel_wide_ff, red: red_layout_ff, green: green_layout_ff,
                     blue: blue_layout_ff, alpha: alpha_layout_ff};

   crf_pixel u_pixel (
      .fill_color (in_color_ff),
      .layout     (layout),
      .pixel      (start_pixel)
   );

   // ------------------------------------------------------------------
   // Fill state: the walk position, the clipped bounds and the pixel.
   // ------------------------------------------------------------------
   logic               busy_ff;
   logic [SIDE_W-1:0]  row_ff;
   logic [SIDE_W-1:0]  col_ff;
   logic [SIDE_W-1:0]  first_col_ff;
   logic [SIDE_W-1:0]  col_end_ff;
   logic [SIDE_W-1:0]  row_end_ff;
   logic [PIXEL_W-1:0] native_pixel_ff;
   logic               is_start;
   logic               step_fire;
   logic               at_col_end;
   logic               at_last;

   assign is_start   = (in_op_ff == OP_START);
   assign step_fire  = consume && !is_start && busy_ff;
   assign at_col_end = (col_ff == col_end_ff);
   assign at_last    = at_col_end && (row_ff == row_end_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff         <= 1'b0;
         row_ff          <= '0;
         col_ff          <= '0;
         first_col_ff    <= '0;
         col_end_ff      <= '0;
         row_end_ff      <= '0;
         native_pixel_ff <= '0;
      end else if (consume) begin
         if (is_start) begin
            // A new rectangle replaces whatever fill was running.
            if (clip_empty) begin
               busy_ff <= 1'b0;
            end else begin
               busy_ff         <= 1'b1;
               row_ff          <= top_s[SIDE_W-1:0];
               col_ff          <= left_s[SIDE_W-1:0];
               first_col_ff    <= left_s[SIDE_W-1:0];
               col_end_ff      <= col_last_s[SIDE_W-1:0];
               row_end_ff      <= row_last_s[SIDE_W-1:0];
               native_pixel_ff <= start_pixel;
            end
         end else if (busy_ff) begin
            if (at_last) begin
               busy_ff <= 1'b0;
            end else if (at_col_end) begin
               col_ff <= first_col_ff;
               row_ff <= row_ff + SIDE_W'(1);
            end else begin
               col_ff <= col_ff + SIDE_W'(1);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Product register: the row offset in bytes and the rest of the write.
   // ------------------------------------------------------------------
   logic [PRODUCT_W-1:0] prod_ff;
   logic [SIDE_W-1:0]    prod_col_ff;
   logic                 prod_last_ff;
   logic                 prod_wide_ff;
   logic [PIXEL_W-1:0]   prod_pixel_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
      end else if (step_fire) begin
         prod_valid_ff <= 1'b1;
      end else if (rsp_free) begin
         prod_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step_fire) begin
         prod_ff       <= {{LB_W{1'b0}}, row_ff} * {{SIDE_W{1'b0}}, row_pitch_ff};
         prod_col_ff   <= col_ff;
         prod_last_ff  <= at_last;
         prod_wide_ff  <= pixel_wide_ff;
         prod_pixel_ff <= native_pixel_ff;
      end
   end

   // ------------------------------------------------------------------
   // Result register. Bytes become pixel words by a shift of one or two.
   // ------------------------------------------------------------------
   logic [PRODUCT_W-1:0] row_words;
   logic [PRODUCT_W-1:0] word_sum;
   logic [INDEX_W-1:0]   rsp_index_ff;
   logic [PIXEL_W-1:0]   rsp_pixel_ff;
   logic                 rsp_last_ff;

   always_comb begin
      row_words = prod_wide_ff ? (prod_ff >> 2) : (prod_ff >> 1);
      word_sum  = row_words + PRODUCT_W'(prod_col_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= prod_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (prod_valid_ff && rsp_free) begin
         rsp_index_ff <= word_sum[INDEX_W-1:0];
         rsp_pixel_ff <= prod_pixel_ff;
         rsp_last_ff  <= prod_last_ff;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.word_index  = rsp_index_ff;
   assign rsp_bus.pixel_value = rsp_pixel_ff;
   assign rsp_bus.last_write  = rsp_last_ff;

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the clipped rectangle fill engine
// A tracker class mirrors the fill engine. It clips each start item, converts
// its color and queues the framebuffer writes that later steps must produce.
// Plain tasks drive the request and register channels with random gaps.
// The result channel stalls at random and is held off once for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

import crf_pkg::*;

typedef struct {
   op_type                    operation;
   logic signed [COORD_W-1:0] rect_x;
   logic signed [COORD_W-1:0] rect_y;
   logic signed [COORD_W-1:0] rect_w;
   logic signed [COORD_W-1:0] rect_h;
   logic        [COLOR_W-1:0] fill_color;
} fill_item_type;

typedef struct {
   logic [INDEX_W-1:0] word_index;
   logic [PIXEL_W-1:0] pixel_value;
   logic               last_write;
} pixel_write_type;

// Mirrors the registers and the fill walk, and holds the writes still owed.
class fill_tracker;
   logic                pixel_wide;
   logic [LAYOUT_W-1:0] red_layout, green_layout, blue_layout, alpha_layout;
   logic [SIDE_W-1:0]   screen_width, screen_height;
   logic [LB_W-1:0]     row_pitch;

   bit                  busy;
   logic [SIDE_W-1:0]   cur_row, cur_col, first_col, last_col, last_row;
   logic [PIXEL_W-1:0]  fill_pixel;

   pixel_write_type     pending_writes[$];
   int unsigned         mismatches;

   function new();
      pixel_wide    = 1'b0;
      red_layout    = RED_LAYOUT_RST;
      green_layout  = GREEN_LAYOUT_RST;
      blue_layout   = BLUE_LAYOUT_RST;
      alpha_layout  = ALPHA_LAYOUT_RST;
      screen_width  = SCREEN_WIDTH_RST;
      screen_height = SCREEN_HEIGHT_RST;
      row_pitch     = PITCH_RST;
      busy          = 1'b0;
      cur_row       = '0;
      cur_col       = '0;
      first_col     = '0;
      last_col      = '0;
      last_row      = '0;
      fill_pixel    = '0;
      mismatches    = 0;
   endfunction

   function void write_register(logic [CSR_INDEX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
      case (csr_index_type'(index))
         CSR_PIXEL_WIDE:    pixel_wide    = data[0];
         CSR_RED_LAYOUT:    red_layout    = data[LAYOUT_W-1:0];
         CSR_GREEN_LAYOUT:  green_layout  = data[LAYOUT_W-1:0];
         CSR_BLUE_LAYOUT:   blue_layout   = data[LAYOUT_W-1:0];
         CSR_ALPHA_LAYOUT:  alpha_layout  = data[LAYOUT_W-1:0];
         CSR_SCREEN_WIDTH:  screen_width  = data[SIDE_W-1:0];
         CSR_SCREEN_HEIGHT: screen_height = data[SIDE_W-1:0];
         CSR_ROW_PITCH:     row_pitch     = data[LB_W-1:0];
         default: ;
      endcase
   endfunction

   function int field_length(logic [LAYOUT_W-1:0] layout);
      return (layout[8:5] > MAX_CHANNEL_LEN) ? int'(MAX_CHANNEL_LEN) : int'(layout[8:5]);
   endfunction

   // Keeps the top bits of the channel byte and moves them to the field offset.
   // The result is wide enough that bits pushed past bit 31 can be dropped later.
   function logic [63:0] place_channel(logic [7:0] chan, logic [LAYOUT_W-1:0] layout);
      logic [63:0] kept;
      kept = 64'(chan) >> (8 - field_length(layout));
      return kept << layout[4:0];
   endfunction

   function logic [PIXEL_W-1:0] convert_color(logic [COLOR_W-1:0] color);
      logic [63:0] px;
      int          alen;
      px = place_channel(color[23:16], red_layout)
         | place_channel(color[15:8], green_layout)
         | place_channel(color[7:0], blue_layout);
      if (!pixel_wide) begin
         return {16'h0000, px[15:0]};
      end
      alen = field_length(alpha_layout);
      if (alen > 0) begin
         px = px | (((64'd1 << alen) - 64'd1) << alpha_layout[4:0]);
      end
      return px[31:0];
   endfunction

   function void note_item(fill_item_type item);
      int              x, y, w, h, sw, sh;
      logic [63:0]     pitch, index;
      pixel_write_type wr;
      if (item.operation == OP_START) begin
         x  = item.rect_x;
         y  = item.rect_y;
         w  = item.rect_w;
         h  = item.rect_h;
         sw = (screen_width > MAX_SIDE) ? MAX_SIDE : int'(screen_width);
         sh = (screen_height > MAX_SIDE) ? MAX_SIDE : int'(screen_height);
         if (x < 0) begin
            w = w + x;
            x = 0;
         end
         if (y < 0) begin
            h = h + y;
            y = 0;
         end
         if (x + w > sw) w = sw - x;
         if (y + h > sh) h = sh - y;
         if (w <= 0 || h <= 0) begin
            busy = 1'b0;
         end else begin
            first_col  = SIDE_W'(x);
            cur_col    = SIDE_W'(x);
            cur_row    = SIDE_W'(y);
            last_col   = SIDE_W'(x + w - 1);
            last_row   = SIDE_W'(y + h - 1);
            fill_pixel = convert_color(item.fill_color);
            busy       = 1'b1;
         end
      end else if (busy) begin
         pitch = (row_pitch > MAX_PITCH) ? 64'(MAX_PITCH) : 64'(row_pitch);
         index = 64'(cur_row) * pitch / (pixel_wide ? 64'd4 : 64'd2) + 64'(cur_col);
         wr.word_index  = index[INDEX_W-1:0];
         wr.pixel_value = fill_pixel;
         wr.last_write  = (cur_row == last_row) && (cur_col == last_col);
         pending_writes.push_back(wr);
         if (wr.last_write) begin
            busy = 1'b0;
         end else if (cur_col == last_col) begin
            cur_col = first_col;
            cur_row = cur_row + 1'b1;
         end else begin
            cur_col = cur_col + 1'b1;
         end
      end
   endfunction

   function void check_write(pixel_write_type got);
      pixel_write_type want;
      if (pending_writes.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("mismatch: write with none owed: index %0d pixel %08h last %0b",
                     got.word_index, got.pixel_value, got.last_write);
         end
         return;
      end
      want = pending_writes.pop_front();
      if (got.word_index !== want.word_index || got.pixel_value !== want.pixel_value ||
          got.last_write !== want.last_write) begin
         mismatches++;
         if (mismatches <= 10) begin
            $display("mismatch: expected index %0d pixel %08h last %0b, got index %0d pixel %08h last %0b",
                     want.word_index, want.pixel_value, want.last_write,
                     got.word_index, got.pixel_value, got.last_write);
         end
      end
   endfunction

   function int unsigned owed();
      return pending_writes.size();
   endfunction
endclass

module tb_top;

   // The engine shows a write only once its step has passed the input, product and
   // result registers; the drain wait adds margin for any bubble still in flight.
   localparam int DRAIN_CYCLES   = 8;
   localparam int PRESSURE_HOLD  = 400;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASE_COUNT    = 12;

   logic clock;
   logic reset;

   crf_req_if req_bus ();
   crf_rsp_if rsp_bus ();
   crf_csr_if csr_bus ();

   clipped_rectangle_fill dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   fill_tracker tracker = new();

   // When set, the sender offers items back to back.
   bit sender_gapless = 1'b0;

   // The stimulus bumps this counter to ask the result side for a long hold-off.
   int pressure_requests = 0;

   initial clock = 1'b0;
   always #1 clock = ~clock;

   // Gap lengths: mostly none or short, now and then a long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(30, 80);
   endfunction

   // ------------------------------------------------------------------------
   // Result side. Ready changes at the falling edge. Short runs of ready are
   // broken by random stalls, and now and then a long run has no stall at
   // all. A pressure request holds ready low for a long stretch, counted here,
   // so the pipeline fills and the engine has to stall its request channel.
   // ------------------------------------------------------------------------
   int stall_left    = 0;
   int run_left      = 0;
   int hold_left     = 0;
   int pressure_seen = 0;

   always @(negedge clock) begin
      if (pressure_seen != pressure_requests) begin
         pressure_seen = pressure_requests;
         hold_left     = PRESSURE_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= 1'b1;
         if (run_left > 0) begin
            run_left--;
         end else begin
            run_left   = ($urandom_range(0, 19) == 0) ? 150 : $urandom_range(0, 12);
            stall_left = pick_gap();
         end
      end
   end

   // ------------------------------------------------------------------------
   // Monitors. Every channel is sampled at the rising edge. The result is
   // checked before the request is noted; a write seen at this edge always
   // belongs to a step taken at an earlier edge.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      pixel_write_type got;
      fill_item_type   item;
      if (!reset) begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.word_index  = rsp_bus.word_index;
            got.pixel_value = rsp_bus.pixel_value;
            got.last_write  = rsp_bus.last_write;
            tracker.check_write(got);
         end
         if (req_bus.valid && req_bus.ready) begin
            item.operation  = op_type'(req_bus.operation);
            item.rect_x     = req_bus.rect_x;
            item.rect_y     = req_bus.rect_y;
            item.rect_w     = req_bus.rect_w;
            item.rect_h     = req_bus.rect_h;
            item.fill_color = req_bus.fill_color;
            tracker.note_item(item);
         end
         if (csr_bus.valid && csr_bus.ready) begin
            tracker.write_register(csr_bus.index, csr_bus.data);
         end
      end
   end

   // The watchdog ends the run when no channel has moved an item for too long.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
             (csr_bus.valid && csr_bus.ready)) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("[clipped_rectangle_fill] ERROR");
      $finish;
   end

   // ------------------------------------------------------------------------
   // Request driver. Each call starts at a falling edge after the previous
   // item was taken, so valid is written once per edge: it either stays high
   // for the next item or drops for a gap. Valid stays up until the engine
   // takes the item.
   // ------------------------------------------------------------------------
   task automatic send_item(fill_item_type item);
      int gap;
      gap = sender_gapless ? 0 : pick_gap();
      @(negedge clock);
      if (gap > 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.operation  = item.operation;
      req_bus.rect_x     = item.rect_x;
      req_bus.rect_y     = item.rect_y;
      req_bus.rect_w     = item.rect_w;
      req_bus.rect_h     = item.rect_h;
      req_bus.fill_color = item.fill_color;
      req_bus.valid      = 1'b1;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   task automatic release_req();
      @(negedge clock);
      req_bus.valid = 1'b0;
   endtask

   task automatic send_start(int x, int y, int w, int h, logic [COLOR_W-1:0] color);
      fill_item_type item;
      item.operation  = OP_START;
      item.rect_x     = COORD_W'(x);
      item.rect_y     = COORD_W'(y);
      item.rect_w     = COORD_W'(w);
      item.rect_h     = COORD_W'(h);
      item.fill_color = color;
      send_item(item);
   endtask

   // A step ignores its rectangle fields, so they carry random bits.
   task automatic send_step();
      fill_item_type item;
      item.operation  = OP_STEP;
      item.rect_x     = COORD_W'($urandom);
      item.rect_y     = COORD_W'($urandom);
      item.rect_w     = COORD_W'($urandom);
      item.rect_h     = COORD_W'($urandom);
      item.fill_color = COLOR_W'($urandom);
      send_item(item);
   endtask

   task automatic csr_write(csr_index_type index, logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      csr_bus.index = index;
      csr_bus.data  = data;
      csr_bus.valid = 1'b1;
      @(posedge clock);
      while (!csr_bus.ready) @(posedge clock);
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   // Waits for every owed write, then idles while the pipe clears.
   task automatic wait_idle();
      while (tracker.owed() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   function automatic logic [CSR_DATA_W-1:0] make_layout(int offset, int length);
      return CSR_DATA_W'((length << 5) | offset);
   endfunction

   function automatic logic [COLOR_W-1:0] random_color();
      case ($urandom_range(0, 7))
         0:       return 24'hFFFFFF;
         1:       return 24'h000000;
         default: return COLOR_W'($urandom_range(0, 24'hFFFFFF));
      endcase
   endfunction

   // Layouts: half legal fields, a quarter raw 9-bit codes, a quarter full 16-bit words.
   function automatic logic [CSR_DATA_W-1:0] random_layout();
      int r;
      r = $urandom_range(0, 3);
      if (r < 2) return make_layout($urandom_range(0, 31), $urandom_range(0, 8));
      if (r == 2) return CSR_DATA_W'($urandom_range(0, 511));
      return CSR_DATA_W'($urandom);
   endfunction

   // Screen sides: mostly small so rectangles finish, some up to the limit and
   // some raw words that may be zero or beyond the largest side.
   function automatic logic [CSR_DATA_W-1:0] random_side();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60) return CSR_DATA_W'($urandom_range(1, 40));
      if (r < 85) return CSR_DATA_W'($urandom_range(1, MAX_SIDE));
      return CSR_DATA_W'($urandom);
   endfunction

   function automatic logic [CSR_DATA_W-1:0] random_pitch();
      int r;
      r = $urandom_range(0, 9);
      if (r < 5) return CSR_DATA_W'($urandom_range(1, 256));
      if (r < 8) return CSR_DATA_W'($urandom_range(1, MAX_PITCH));
      return CSR_DATA_W'($urandom);
   endfunction

   // Programs every register for one phase. The first phases pin down the
   // usual 565 and 8888 formats and the low, high and out-of-range extremes;
   // later phases pick values at random.
   task automatic apply_setting(int phase);
      logic [CSR_DATA_W-1:0] wide, red, green, blue, alpha, sw, sh, pitch;
      case (phase)
         0: begin
            wide = 0; red = make_layout(11, 5); green = make_layout(5, 6);
            blue = make_layout(0, 5); alpha = 0; sw = 8; sh = 6; pitch = 16;
         end
         1: begin
            // Lowest legal values: every channel empty, a one-pixel screen.
            wide = 0; red = 0; green = 0; blue = 0; alpha = 0; sw = 1; sh = 1; pitch = 1;
         end
         2: begin
            wide = 1; red = 287; green = 287; blue = 287; alpha = 287;
            sw = CSR_DATA_W'(MAX_SIDE); sh = CSR_DATA_W'(MAX_SIDE);
            pitch = CSR_DATA_W'(MAX_PITCH);
         end
         3: begin
            // Lengths above eight, sides and pitch above their limits.
            wide = 1; red = make_layout(0, 15); green = make_layout(8, 15);
            blue = make_layout(31, 15); alpha = make_layout(24, 15);
            sw = 8191; sh = 5000; pitch = 32767;
         end
         4: begin
            // A screen of zero width: every start clips to nothing.
            wide = 0; red = random_layout(); green = random_layout();
            blue = random_layout(); alpha = random_layout(); sw = 0; sh = 100; pitch = 100;
         end
         5: begin
            wide = 1; red = make_layout(16, 8); green = make_layout(8, 8);
            blue = make_layout(0, 8); alpha = make_layout(24, 8); sw = 64; sh = 48; pitch = 256;
         end
         default: begin
            wide  = ($urandom_range(0, 7) == 0) ? CSR_DATA_W'($urandom)
                                                : CSR_DATA_W'($urandom_range(0, 1));
            red   = random_layout();
            green = random_layout();
            blue  = random_layout();
            alpha = random_layout();
            sw    = random_side();
            sh    = random_side();
            pitch = random_pitch();
         end
      endcase
      csr_write(CSR_PIXEL_WIDE, wide);
      csr_write(CSR_RED_LAYOUT, red);
      csr_write(CSR_GREEN_LAYOUT, green);
      csr_write(CSR_BLUE_LAYOUT, blue);
      csr_write(CSR_ALPHA_LAYOUT, alpha);
      csr_write(CSR_SCREEN_WIDTH, sw);
      csr_write(CSR_SCREEN_HEIGHT, sh);
      csr_write(CSR_ROW_PITCH, pitch);
   endtask

   function automatic int pick_extreme(int side);
      case ($urandom_range(0, 5))
         0:       return -32768;
         1:       return 32767;
         2:       return -1;
         3:       return 0;
         4:       return side - 1;
         default: return side;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Random traffic for one phase. Most of it is a start followed by about as
   // many steps as the clipped rectangle holds, so fills run to their last
   // write; some fills are cut short by the next start, some get extra steps
   // past the end. The rest is raw noise, lone steps and starts at extreme
   // coordinates. A phase opens with a few steps that carry on any fill left
   // running from before the registers were rewritten.
   // ------------------------------------------------------------------------
   task automatic run_phase(int target);
      int            sent, kind, x, y, w, h, sw, sh, cw, ch, area, steps;
      fill_item_type item;
      sw = (tracker.screen_width > MAX_SIDE) ? MAX_SIDE : int'(tracker.screen_width);
      sh = (tracker.screen_height > MAX_SIDE) ? MAX_SIDE : int'(tracker.screen_height);
      steps = $urandom_range(0, 3);
      repeat (steps) send_step();
      sent = steps;
      while (sent < target) begin
         sender_gapless = ($urandom_range(0, 6) == 0);
         kind = $urandom_range(0, 99);
         if (kind < 72) begin
            x = int'($urandom_range(0, sw + 8)) - 8;
            y = int'($urandom_range(0, sh + 8)) - 8;
            w = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, sw + 16))
                                            : int'($urandom_range(0, 18)) - 2;
            h = ($urandom_range(0, 9) == 0) ? int'($urandom_range(0, sh + 16))
                                            : int'($urandom_range(0, 18)) - 2;
            send_start(x, y, w, h, random_color());
            cw   = ((x + w < sw) ? x + w : sw) - ((x > 0) ? x : 0);
            ch   = ((y + h < sh) ? y + h : sh) - ((y > 0) ? y : 0);
            area = (w > 0 && h > 0 && cw > 0 && ch > 0) ? cw * ch : 0;
            if (area > 64) begin
               steps = $urandom_range(8, 64);
            end else if ($urandom_range(0, 6) == 0) begin
               steps = $urandom_range(0, area);
            end else begin
               steps = area + $urandom_range(0, 2);
            end
            repeat (steps) send_step();
            sent += steps + 1;
         end else if (kind < 86) begin
            item.operation  = op_type'($urandom_range(0, 1));
            item.rect_x     = COORD_W'($urandom);
            item.rect_y     = COORD_W'($urandom);
            item.rect_w     = COORD_W'($urandom);
            item.rect_h     = COORD_W'($urandom);
            item.fill_color = COLOR_W'($urandom);
            send_item(item);
            sent++;
         end else if (kind < 94) begin
            steps = $urandom_range(1, 4);
            repeat (steps) send_step();
            sent += steps;
         end else begin
            send_start(pick_extreme(sw), pick_extreme(sh), pick_extreme(sw), pick_extreme(sh),
                       random_color());
            steps = $urandom_range(0, 8);
            repeat (steps) send_step();
            sent += steps + 1;
         end
      end
      sender_gapless = 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Main sequence.
   // ------------------------------------------------------------------------
   initial begin
      int phase;
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.operation  = OP_START;
      req_bus.rect_x     = '0;
      req_bus.rect_y     = '0;
      req_bus.rect_w     = '0;
      req_bus.rect_h     = '0;
      req_bus.fill_color = '0;
      rsp_bus.ready      = 1'b0;
      csr_bus.valid      = 1'b0;
      csr_bus.index      = CSR_PIXEL_WIDE;
      csr_bus.data       = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed items under the reset format, an 800 by 480 screen in 565.
      // A step with no fill running yields nothing.
      send_step();
      // A rectangle hanging off the top-left corner clips to 3 by 2; the
      // seventh step comes after the last write and yields nothing.
      send_start(-3, -2, 6, 4, 24'hFFFFFF);
      repeat (7) send_step();
      // Zero width, and the most negative width with the largest height: no writes.
      send_start(0, 0, 0, 5, 24'h00FF00);
      send_step();
      send_start(32767, -32768, -32768, 32767, 24'h000000);
      // Far off to the left and top: the width left after clipping is negative.
      send_start(-32768, -32768, 32767, 32767, 24'h123456);
      // The bottom-right pixel alone, with the largest sizes clipped away.
      send_start(799, 479, 32767, 32767, 24'h000000);
      repeat (2) send_step();
      // A new start replaces a fill that is still running.
      send_start(10, 20, 4, 3, 24'hA5C3F0);
      repeat (2) send_step();
      send_start(797, 478, 2, 2, 24'h5A3C0F);
      repeat (4) send_step();
      // This fill is still running when the registers change; its pixel and
      // clip stay, while the new pitch and pixel width apply to its writes.
      send_start(1, 1, 3, 3, 24'hC0FFEE);

      for (phase = 0; phase < PHASE_COUNT; phase++) begin
         release_req();
         wait_idle();
         apply_setting(phase);
         run_phase((phase == 4) ? 40 : 85);
         if (phase == 5) begin
            // Hold the result side off while the sender keeps offering steps
            // of a large fill, so the engine fills up and stops taking items.
            pressure_requests++;
            sender_gapless = 1'b1;
            send_start(0, 0, 64, 48, random_color());
            repeat (150) send_step();
            sender_gapless = 1'b0;
         end
      end

      release_req();
      while (tracker.owed() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (tracker.mismatches == 0) begin
         $display("[clipped_rectangle_fill] OK");
      end else begin
         $display("[clipped_rectangle_fill] ERROR");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/crf_pkg.sv
rtl/core/crf_if.sv
rtl/core/crf_pixel.sv
rtl/core/clipped_rectangle_fill.sv
tb/sv/tb_top.sv
